// ===== hw/rtl/mi_pkg.sv =====
package mi_pkg;

  localparam int unsigned OperandW         = 32;
  localparam int unsigned ModulusW         = 31;
  localparam int unsigned DataWidthDefault = 32;
  // signed coefficient width: every shifted coefficient stays below the modulus in magnitude
  localparam int unsigned CoefW            = 34;
  localparam logic [ModulusW-1:0] ModulusReset = 31'd1000000007;

  typedef struct packed {
    logic load;
    logic align;
    logic reduce;
    logic swap;
    logic fix_neg;
    logic fix_high;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic align_more;
    logic k_zero;
    logic rem_zero;
  } status_t;

endpackage

// ===== hw/rtl/mi_ctrl.sv =====
module mi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mi_pkg::status_t status_i,
  output mi_pkg::cmd_t    cmd_o
);
  import mi_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ALIGN  = 3'd1;
  localparam logic [2:0] S_REDUCE = 3'd2;
  localparam logic [2:0] S_SWAP   = 3'd3;
  localparam logic [2:0] S_FIXN   = 3'd4;
  localparam logic [2:0] S_FIXH   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.mod_zero ? S_FIXN : S_ALIGN;
        end
      end
      S_ALIGN: begin
        // widen the divisor until one more doubling would pass the remainder
        if (status_i.align_more) begin
          cmd_o.align = 1'b1;
        end else begin
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.reduce = 1'b1;
        if (status_i.k_zero) begin
          state_d = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd_o.swap = 1'b1;
        state_d    = status_i.rem_zero ? S_FIXN : S_ALIGN;
      end
      S_FIXN: begin
        cmd_o.fix_neg = 1'b1;
        state_d       = S_FIXH;
      end
      S_FIXH: begin
        cmd_o.fix_high = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_ALIGN || state_q == S_FIXN)
    else $error("transaction accepted but controller stayed idle");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("result loaded but not presented");

  a_last_reduce_swaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REDUCE && status_i.k_zero |=> state_q == S_SWAP)
    else $error("division did not end in a swap");

endmodule

// ===== hw/rtl/mi_datapath.sv =====
module mi_datapath #(
  parameter int unsigned DATA_WIDTH = mi_pkg::DataWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mi_pkg::ModulusW-1:0]   cfg_data_i,
  input  logic [mi_pkg::OperandW-1:0]   operand_i,
  input  mi_pkg::cmd_t                  cmd_i,
  output mi_pkg::status_t               status_o,
  output logic [mi_pkg::ModulusW-1:0]   inverse_o,
  output logic                          invertible_o
);
  import mi_pkg::*;

  localparam int unsigned RW = (DATA_WIDTH > OperandW) ? DATA_WIDTH : OperandW;
  localparam int unsigned KW = $clog2(RW);
  localparam logic [RW-1:0] OpMask = {RW{1'b1}} >> (RW - DATA_WIDTH);

  logic [ModulusW-1:0]     modulus_q;
  logic [RW-1:0]           a_q, b_q, d_q;
  logic signed [CoefW-1:0] c0_q, c1_q, e_q;
  logic [KW-1:0]           k_q;
  logic [ModulusW-1:0]     inverse_q;
  logic                    invertible_q;

  logic [RW-1:0]           mod_ext, op_ext, diff;
  logic signed [CoefW-1:0] mod_coef;
  logic                    mod_zero, rem_ge;

  assign mod_ext  = RW'(modulus_q);
  assign mod_coef = $signed(CoefW'(modulus_q));
  assign op_ext   = RW'(operand_i) & OpMask;
  assign mod_zero = (modulus_q == '0);
  assign rem_ge   = (a_q >= d_q);
  assign diff     = a_q - d_q;

  assign status_o.mod_zero   = mod_zero;
  assign status_o.align_more = ({d_q, 1'b0} <= {1'b0, a_q});
  assign status_o.k_zero     = (k_q == '0);
  assign status_o.rem_zero   = (a_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_data_i;
    end
  end

  // a/b hold the remainder pair, c0/c1 the coefficient pair, d/e the shifted divisor and c1
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      // first division reduces the operand; c1 of zero keeps c0 untouched there
      a_q  <= mod_zero ? '0 : op_ext;
      b_q  <= mod_ext;
      d_q  <= mod_ext;
      c0_q <= mod_zero ? '0 : CoefW'(1);
      c1_q <= '0;
      e_q  <= '0;
      k_q  <= '0;
    end else if (cmd_i.align) begin
      d_q <= d_q << 1;
      e_q <= e_q <<< 1;
      k_q <= k_q + KW'(1);
    end else if (cmd_i.reduce) begin
      if (rem_ge) begin
        a_q  <= diff;
        c0_q <= c0_q - e_q;
      end
      if (k_q != '0) begin
        d_q <= d_q >> 1;
        e_q <= e_q >>> 1;
        k_q <= k_q - KW'(1);
      end
    end else if (cmd_i.swap) begin
      a_q  <= b_q;
      b_q  <= a_q;
      d_q  <= a_q;
      c0_q <= c1_q;
      c1_q <= c0_q;
      e_q  <= c0_q;
      k_q  <= '0;
    end else if (cmd_i.fix_neg) begin
      if (c0_q < 0) begin
        c0_q <= c0_q + mod_coef;
      end
    end else if (cmd_i.fix_high) begin
      if (c0_q >= mod_coef) begin
        c0_q <= c0_q - mod_coef;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      inverse_q    <= c0_q[ModulusW-1:0];
      invertible_q <= (a_q == RW'(1));
    end
  end

  assign inverse_o    = inverse_q;
  assign invertible_o = invertible_q;

  a_coef_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fix_high |=> !c0_q[CoefW-1] && (c0_q < mod_coef || mod_zero))
    else $error("coefficient not reduced below the modulus");

  a_swap_moves_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.swap |=> d_q == b_q && e_q == c1_q && k_q == '0)
    else $error("divisor copy out of step with remainder pair");

endmodule

// ===== hw/rtl/modular_inverse_unit.sv =====
// Modular inverse by the extended Euclidean algorithm. Each operand transaction gives one
// result: the Bezout coefficient reduced into 0 .. modulus-1, and a flag that is set when the
// gcd of operand and modulus is one (when clear, the coefficient is still given). Only the low
// DATA_WIDTH bits of the operand are used. The modulus register is written through cfg_we_i;
// the user must write it only while the unit is idle, as the unit itself does not enforce
// this. It resets to 1000000007; a modulus of zero gives 0 with the flag clear. One operand
// is processed at a time by a shift-and-subtract divider that also updates the coefficient.
// Each division lines the divisor up under the remainder, subtracts it bit by bit and then
// swaps the pairs; the first division reduces the operand by the modulus. After the last
// division the coefficient is brought into range and the result is loaded to the output.
// The number of Euclid steps sets how long an operand takes. The next operand is taken
// while a finished result waits at the output.
module modular_inverse_unit #(
  parameter int unsigned DATA_WIDTH = mi_pkg::DataWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mi_pkg::ModulusW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mi_pkg::OperandW-1:0]   operand_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mi_pkg::ModulusW-1:0]   inverse_o,
  output logic                          invertible_o
);
  import mi_pkg::*;

  cmd_t    cmd;
  status_t status;

  mi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mi_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .operand_i    (operand_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .inverse_o    (inverse_o),
    .invertible_o (invertible_o)
  );

endmodule

// ===== verif/mi_checker.sv =====
`timescale 1ns / 100ps

module mi_checker #(
  parameter int unsigned DATA_WIDTH = mi_pkg::DataWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mi_pkg::ModulusW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic [mi_pkg::OperandW-1:0] operand_i,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [mi_pkg::ModulusW-1:0] inverse_o,
  input  logic                        invertible_o,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  import mi_pkg::*;

  typedef struct packed {
    logic [ModulusW-1:0] inverse;
    logic                invertible;
  } inverse_t;

  logic [ModulusW-1:0] modulus_q;
  inverse_t            expected_q[$];
  inverse_t            got;
  inverse_t            want;

  // extended euclid on signed 64-bit values, magnitudes stay below 2^32
  function automatic inverse_t predict_inverse(input logic [ModulusW-1:0] m,
                                               input logic [OperandW-1:0] operand);
    longint   mm;
    longint   x;
    longint   r0;
    longint   r1;
    longint   c0;
    longint   c1;
    longint   q;
    longint   t;
    inverse_t res;
    res = '0;
    if (m == '0) begin
      return res;
    end
    mm = m;
    x  = operand;
    if (DATA_WIDTH < OperandW) begin
      x = x & ((longint'(1) << DATA_WIDTH) - 1);
    end
    r0 = x % mm;
    r1 = mm;
    c0 = 1;
    c1 = 0;
    while (r1 != 0) begin
      q  = r0 / r1;
      t  = r0 - q * r1;
      r0 = r1;
      r1 = t;
      t  = c0 - q * c1;
      c0 = c1;
      c1 = t;
    end
    c0 = c0 % mm;
    if (c0 < 0) begin
      c0 = c0 + mm;
    end
    res.inverse    = c0[ModulusW-1:0];
    res.invertible = (r0 == 1);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    = ModulusReset;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.inverse    = inverse_o;
        got.invertible = invertible_o;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result with nothing expected: inverse %0d invertible %0b",
                     $realtime, got.inverse, got.invertible);
          end
        end else begin
          want = expected_q.pop_front();
          if (got.inverse !== want.inverse || got.invertible !== want.invertible) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: mismatch: inverse exp %0d got %0d, invertible exp %0b got %0b",
                       $realtime, want.inverse, got.inverse, want.invertible,
                       got.invertible);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(predict_inverse(modulus_q, operand_i));
      end
      // the bench must write the modulus only while nothing is in flight; this checker does not enforce it
      if (cfg_we_i) begin
        modulus_q = cfg_data_i;
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  import mi_pkg::*;

  localparam int unsigned NumPhases  = 11;
  localparam int unsigned HoldAt     = 320;
  localparam int unsigned HoldCycles = 1500;
  localparam int unsigned CalmFrom   = 600;
  localparam int unsigned CalmTo     = 800;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [ModulusW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [OperandW-1:0] operand_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [ModulusW-1:0] inverse_o;
  logic                invertible_o;

  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         sent_count   = 0;
  bit                  held         = 1'b0;
  logic [ModulusW-1:0] cur_mod;

  // operands around the default prime: small values, multiples of it, its neighbours, (p+1)/2, word extremes
  logic [OperandW-1:0] directed_ops [14] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd1000000006, 32'd1000000007, 32'd1000000008,
    32'd500000004, 32'd2000000014, 32'd4000000028, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  // first entry keeps the reset modulus, the last three get random moduli
  logic [ModulusW-1:0] phase_mod [NumPhases] = '{
    31'd0, 31'h7FFF_FFFF, 31'd2, 31'd1, 31'd0, 31'h4000_0000, 31'd223092870,
    31'd1000000, 31'd0, 31'd0, 31'd0
  };
  int unsigned         phase_len [NumPhases] = '{
    400, 200, 60, 30, 30, 100, 150, 100, 100, 100, 100
  };

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  modular_inverse_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operand_i   (operand_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .inverse_o   (inverse_o),
    .invertible_o(invertible_o)
  );

  mi_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operand_i   (operand_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .inverse_o   (inverse_o),
    .invertible_o(invertible_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic bit calm();
    return sent_count >= CalmFrom && sent_count < CalmTo;
  endfunction

  // mix of small values, values next to multiples of the modulus, values near the top of the word and raw words
  function automatic logic [OperandW-1:0] pick_operand(input logic [ModulusW-1:0] m);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0: return OperandW'($urandom_range(0, 16));
      1: return OperandW'(m) * OperandW'($urandom_range(0, 4))
                + OperandW'($urandom_range(0, 2)) - OperandW'(1);
      2: return 32'hFFFF_FFFF - OperandW'($urandom_range(0, 8));
      default: return OperandW'($urandom());
    endcase
  endfunction

  // called and left at a falling edge
  task automatic send_operand(input logic [OperandW-1:0] value);
    while (!calm() && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operand_i  <= value;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    sent_count++;
    @(negedge clk_i);
  endtask

  // result side: random back-pressure plus one long hold-off that fills the unit
  initial begin
    forever begin
      @(negedge clk_i);
      if (!held && sent_count >= HoldAt) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        for (int unsigned n = 0; n < HoldCycles; n++) begin
          @(negedge clk_i);
        end
      end
      out_ready_i <= calm() ? 1'b1 : ($urandom_range(0, 99) >= 19);
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  <= 1'b1;
    cur_mod = ModulusReset;
    @(negedge clk_i);
    foreach (directed_ops[i]) begin
      send_operand(directed_ops[i]);
    end
    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        // drain before touching the modulus
        in_valid_i <= 1'b0;
        while (pending != 0) begin
          @(negedge clk_i);
        end
        repeat (4) @(negedge clk_i);
        cur_mod = (p >= 8) ? ModulusW'($urandom_range(2, 32'h7FFF_FFFF)) : phase_mod[p];
        cfg_we_i   <= 1'b1;
        cfg_data_i <= cur_mod;
        @(negedge clk_i);
        cfg_we_i   <= 1'b0;
        @(negedge clk_i);
      end
      for (int unsigned i = 0; i < phase_len[p]; i++) begin
        send_operand(pick_operand(cur_mod));
      end
    end
    in_valid_i <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (400) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mi_pkg.sv
hw/rtl/mi_ctrl.sv
hw/rtl/mi_datapath.sv
hw/rtl/modular_inverse_unit.sv
verif/mi_checker.sv
verif/tb.sv
